// ===== rtl/tvve_pkg.sv =====
`timescale 1ns / 1ps

package tvve_pkg;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam int CSR_W      = 7;
   localparam int COORD_W    = 6;
   localparam int CELL_W     = 8;
   localparam int ENERGY_W   = 14;
   localparam int ENERGY_MAX = 8191;
   localparam int ENERGY_MIN = -8192;

   localparam logic [CSR_W-1:0] GRID_RESET = 7'd64;

   typedef struct packed {
      logic idle;      // ready for a new transaction
      logic acc_clr;   // clear accumulator
      logic acc_add;   // read data valid, add it
      logic done;      // result ready to hand over
      logic bad;       // site outside grid
   } seq_ctrl_type;

endpackage

// ===== rtl/tvve_lattice_mem.sv =====
`timescale 1ns / 1ps

module tvve_lattice_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic                             we,
   input  logic [ADDR_W-1:0]                addr,
   input  logic [tvve_pkg::CELL_W-1:0]      wdata,
   output logic [tvve_pkg::CELL_W-1:0]      rdata
);

   logic [tvve_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tvve_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tvve_seq.sv =====
`timescale 1ns / 1ps

module tvve_seq #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_HEIGHT    = 64,
   parameter int WINDOW_RADIUS = 2,
   parameter int XW            = 6,
   parameter int YW            = 6,
   parameter int ADDR_W        = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tvve_pkg::COORD_W-1:0]      site_x,
   input  logic [tvve_pkg::COORD_W-1:0]      site_y,
   input  logic [XW:0]                       w_eff,
   input  logic [YW:0]                       h_eff,
   input  logic                              out_free,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   output tvve_pkg::seq_ctrl_type            ctrl
);

   localparam int SPAN  = 2 * WINDOW_RADIUS + 1;
   localparam int CNT_W = $clog2(SPAN);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [XW-1:0]    ex_ff, ex_in;
   logic [YW-1:0]    ey_ff, ey_in;
   logic [YW-1:0]    ey0_ff, ey0_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             bad_ff, bad_in;
   logic             add_ff;

   logic [XW-1:0] ex_dec, ex_inc;
   logic [YW-1:0] ey_dec, ey_inc;
   logic          bad_site;

   // wrapped unit steps
   always_comb begin
      ex_dec = (ex_ff == '0) ? XW'(w_eff - 1'b1) : XW'(ex_ff - 1'b1);
      ex_inc = ({1'b0, ex_ff} == w_eff - 1'b1) ? '0 : XW'(ex_ff + 1'b1);
      ey_dec = (ey_ff == '0) ? YW'(h_eff - 1'b1) : YW'(ey_ff - 1'b1);
      ey_inc = ({1'b0, ey_ff} == h_eff - 1'b1) ? '0 : YW'(ey_ff + 1'b1);
   end

   assign bad_site = (32'(site_x) >= 32'(w_eff)) || (32'(site_y) >= 32'(h_eff));

   always_comb begin
      state_in = state_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      ey0_in   = ey0_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      bad_in   = bad_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ex_in  = XW'(site_x);
               ey_in  = YW'(site_y);
               col_in = '0;
               row_in = '0;
               bad_in = bad_site;
               state_in = bad_site ? S_DONE : S_PREP;
            end
         end
         S_PREP: begin
            // walk back to the window corner, one step per cycle
            ex_in  = ex_dec;
            ey_in  = ey_dec;
            ey0_in = ey_dec;
            col_in = CNT_W'(col_ff + 1'b1);
            if (32'(col_ff) == WINDOW_RADIUS - 1) begin
               col_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (32'(row_ff) == SPAN - 1) begin
               row_in = '0;
               ey_in  = ey0_ff;
               ex_in  = ex_inc;
               col_in = CNT_W'(col_ff + 1'b1);
               if (32'(col_ff) == SPAN - 1) begin
                  state_in = S_LAST;
               end
            end else begin
               row_in = CNT_W'(row_ff + 1'b1);
               ey_in  = ey_inc;
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         add_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         add_ff   <= rd_en;
      end
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      ey0_ff <= ey0_in;
      col_ff <= col_in;
      row_ff <= row_in;
      bad_ff <= bad_in;
   end

   assign rd_en   = (state_ff == S_SCAN);
   assign rd_addr = ADDR_W'(ADDR_W'(ex_ff) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(ey_ff));

   always_comb begin
      ctrl.idle    = (state_ff == S_IDLE);
      ctrl.acc_clr = (state_ff == S_IDLE) && start;
      ctrl.acc_add = add_ff;
      ctrl.done    = (state_ff == S_DONE);
      ctrl.bad     = bad_ff;
   end

endmodule

// ===== rtl/torus_window_vacancy_energy.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                                    Direction
// request   req_valid/req_ready, req_type, req_site_x/y, req_cell_value   in
// response  rsp_valid/rsp_ready, rsp_energy, rsp_bad_coord           out
// csr       csr_we, csr_index, csr_wdata                             in
//
// A write transaction completes on acceptance and gives no response.
// After a query is accepted, req_ready stays low while the sequencer walks back to the
// window corner (PREP), reads the (2*WINDOW_RADIUS+1)^2 window cells through the single
// lattice memory port, one cell read per cycle (SCAN), passes LAST and waits in DONE;
// rsp_valid rises as it leaves DONE. An off-grid query goes straight to DONE. Both stretch
// while a finished query waits on a full response register.
// Synchronous active-high reset clears control and sets the grid size registers to
// 64 x 64; the lattice itself is not cleared.
module torus_window_vacancy_energy #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_HEIGHT    = 64,
   parameter int WINDOW_RADIUS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [tvve_pkg::COORD_W-1:0]         req_site_x,
   input  logic [tvve_pkg::COORD_W-1:0]         req_site_y,
   input  logic [tvve_pkg::CELL_W-1:0]          req_cell_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tvve_pkg::ENERGY_W-1:0] rsp_energy,
   output logic                                 rsp_bad_coord,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [tvve_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SPAN   = 2 * WINDOW_RADIUS + 1;
   localparam int ACC_W  = $clog2(255 * SPAN * SPAN + 1) + 2;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(tvve_pkg::ENERGY_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(tvve_pkg::ENERGY_MIN);

   logic [tvve_pkg::CSR_W-1:0] grid_width_ff, grid_height_ff;
   logic [XW:0]                w_eff;
   logic [YW:0]                h_eff;

   tvve_pkg::seq_ctrl_type ctrl;
   logic                   accept, wr_ok, start, out_free;
   logic                   rd_en, mem_en;
   logic [ADDR_W-1:0]      rd_addr, wr_addr, mem_addr;
   logic [tvve_pkg::CELL_W-1:0] rdata;

   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff;
   logic signed [tvve_pkg::ENERGY_W-1:0] energy_ff, energy_in;
   logic                       bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= tvve_pkg::GRID_RESET;
         grid_height_ff <= tvve_pkg::GRID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tvve_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            tvve_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // extents clamped to the store size
   assign w_eff = (32'(grid_width_ff) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH)
                                                   : (XW+1)'(grid_width_ff);
   assign h_eff = (32'(grid_height_ff) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT)
                                                     : (YW+1)'(grid_height_ff);

   assign req_ready = ctrl.idle;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_type == tvve_pkg::REQ_QUERY);
   assign wr_ok     = accept && (req_type == tvve_pkg::REQ_WRITE)
                      && (32'(req_site_x) < MAX_WIDTH) && (32'(req_site_y) < MAX_HEIGHT);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign wr_addr  = ADDR_W'(ADDR_W'(req_site_x) * ADDR_W'(MAX_HEIGHT)
                             + ADDR_W'(req_site_y));
   assign mem_en   = wr_ok || rd_en;
   assign mem_addr = wr_ok ? wr_addr : rd_addr;

   tvve_lattice_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (wr_ok),
      .addr  (mem_addr),
      .wdata (req_cell_value),
      .rdata (rdata)
   );

   tvve_seq #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .WINDOW_RADIUS (WINDOW_RADIUS),
      .XW            (XW),
      .YW            (YW),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .site_x   (req_site_x),
      .site_y   (req_site_y),
      .w_eff    (w_eff),
      .h_eff    (h_eff),
      .out_free (out_free),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .ctrl     (ctrl)
   );

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + ACC_W'(1) - $signed({{(ACC_W-tvve_pkg::CELL_W){1'b0}}, rdata});
      end
   end

   always_comb begin
      if (ctrl.bad) begin
         energy_in = '0;
      end else if (acc_ff > SAT_HI) begin
         energy_in = tvve_pkg::ENERGY_W'(tvve_pkg::ENERGY_MAX);
      end else if (acc_ff < SAT_LO) begin
         energy_in = tvve_pkg::ENERGY_W'(tvve_pkg::ENERGY_MIN);
      end else begin
         energy_in = tvve_pkg::ENERGY_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      acc_ff <= acc_in;
      if (ctrl.done && out_free) begin
         energy_ff <= energy_in;
         bad_ff    <= ctrl.bad;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = energy_ff;
   assign rsp_bad_coord = bad_ff;

endmodule
